// ===== hdl/chbt_pkg.sv =====
// shared types and constants for the chained hash bucket table
// no dependencies
package chbt_pkg;

   localparam int DEF_BUCKETS     = 1024;
   localparam int DEF_CHAIN_DEPTH = 8;

   localparam int INFO_W  = 31;
   localparam int HASH_W  = 32;
   localparam int COLL_W  = 14;
   localparam int BCNT_W  = 11;
   localparam int REQ_W   = 72;
   localparam int RSP_W   = 48;

   localparam logic [1:0] ACT_ADD   = 2'd0;
   localparam logic [1:0] ACT_DEL   = 2'd1;
   localparam logic [1:0] ACT_EXIST = 2'd2;
   localparam logic [1:0] ACT_LIST  = 2'd3;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   localparam logic [BCNT_W-1:0] BCNT_RESET = 11'd1024;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DIV,
      S_HRD,
      S_HEAD,
      S_PRD,
      S_PDAT,
      S_SCRD,
      S_SCHK,
      S_SRD,
      S_SWR,
      S_FIN,
      S_LHEAD,
      S_LRD,
      S_LDAT,
      S_EMIT
   } state_type;

endpackage

// ===== hdl/chained_hash_bucket_table.sv =====
// chained hash bucket table: head memory, chain memory, bucket divider and control
// depends on chbt_pkg
// sequence: the divide is skipped when |hash| < bucket count, else one remainder bit a cycle,
// then the head read, then each chain entry walked, shifted or listed
// one request at a time: a new one is taken only in the idle state
// reset: synchronous; a clearing pass over every bucket empties every head before the
// first beat is taken, the chain memory is not cleared
module chained_hash_bucket_table #(
   parameter int BUCKETS     = chbt_pkg::DEF_BUCKETS,
   parameter int CHAIN_DEPTH = chbt_pkg::DEF_CHAIN_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   // request: action[1:0], hash_value[33:2], info[64:34], zero fill
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [chbt_pkg::REQ_W-1:0]  req_tdata,
   // response: status[1:0], info_out[32:2], collision_count[46:33], zero fill
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [chbt_pkg::RSP_W-1:0]  rsp_tdata,
   output logic                        rsp_tlast,
   // bucket_count register
   input  logic                        csr_wen,
   input  logic [chbt_pkg::BCNT_W-1:0] csr_wdata
);

   // widths derived from the table geometry
   localparam int BW     = $clog2(BUCKETS);
   localparam int NW     = $clog2(BUCKETS + 1);
   localparam int LEN_W  = $clog2(CHAIN_DEPTH + 1);
   localparam int SLOT_W = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;
   localparam int HW     = 1 + chbt_pkg::INFO_W + LEN_W;
   localparam int CW     = $clog2(BUCKETS * CHAIN_DEPTH + 1);
   localparam int CADR_W = BW + SLOT_W;
   localparam int IW     = chbt_pkg::INFO_W;

   // memories: head word is {valid, info, chain length}
   logic [HW-1:0] head_mem [BUCKETS];
   logic [IW-1:0] chain_mem [BUCKETS << SLOT_W];

   logic [HW-1:0]     head_q;
   logic              head_we;
   logic [BW-1:0]     head_waddr;
   logic [HW-1:0]     head_wdata;
   logic [IW-1:0]     chain_q;
   logic              chain_we;
   logic [CADR_W-1:0] chain_waddr;
   logic [CADR_W-1:0] chain_raddr;
   logic [IW-1:0]     chain_wdata;

   chbt_pkg::state_type state_ff, state_in;

   logic [chbt_pkg::BCNT_W-1:0] bc_ff, bc_in;
   logic [BW-1:0]     clr_ff, clr_in;
   logic [BW-1:0]     bucket_ff, bucket_in;
   logic [31:0]       mag_ff, mag_in;
   logic [NW-1:0]     rem_ff, rem_in;
   logic [NW-1:0]     n_ff, n_in;
   logic [4:0]        dcnt_ff, dcnt_in;
   logic [1:0]        action_ff, action_in;
   logic [IW-1:0]     info_ff, info_in;
   logic [IW-1:0]     hinfo_ff, hinfo_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  idx_ff, idx_in;
   logic [1:0]        status_ff, status_in;
   logic [CW-1:0]     coll_ff, coll_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [IW-1:0]     rsp_info_ff, rsp_info_in;
   logic              rsp_last_ff, rsp_last_in;
   logic [chbt_pkg::COLL_W-1:0] rsp_coll_ff, rsp_coll_in;

   // effective bucket count, clamped to 1..BUCKETS
   logic [31:0]   bc_ext;
   logic [31:0]   n_full;
   logic [NW-1:0] n_eff;
   // magnitude of the incoming hash, most negative value included
   logic [31:0]   req_hash;
   logic [31:0]   req_mag;
   // one restoring remainder step
   logic [NW:0]   rem_sh;
   logic [NW:0]   rem_sub;
   logic [NW-1:0] rem_next;
   // head word fields
   logic              hq_valid;
   logic [IW-1:0]     hq_info;
   logic [LEN_W-1:0]  hq_len;
   logic              out_free;
   logic [LEN_W-1:0]  idx_inc;
   logic [CW+chbt_pkg::COLL_W-1:0] coll_ext;

   assign bc_ext   = {21'd0, bc_ff};
   assign n_full   = (bc_ext == 32'd0) ? 32'd1 :
                     ((bc_ext > 32'(BUCKETS)) ? 32'(BUCKETS) : bc_ext);
   assign n_eff    = n_full[NW-1:0];

   assign req_hash = req_tdata[33:2];
   assign req_mag  = req_hash[31] ? (~req_hash + 32'd1) : req_hash;

   assign rem_sh   = {rem_ff, mag_ff[31]};
   assign rem_sub  = rem_sh - {1'b0, n_ff};
   assign rem_next = (rem_sh >= {1'b0, n_ff}) ? rem_sub[NW-1:0] : rem_sh[NW-1:0];

   assign hq_valid = head_q[HW-1];
   assign hq_info  = head_q[LEN_W +: IW];
   assign hq_len   = head_q[LEN_W-1:0];

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign idx_inc  = idx_ff + LEN_W'(1);
   assign coll_ext = {{chbt_pkg::COLL_W{1'b0}}, coll_ff};

   assign chain_raddr = {bucket_ff, idx_ff[SLOT_W-1:0]};

   assign req_tready = (state_ff == chbt_pkg::S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {1'b0, rsp_coll_ff, rsp_info_ff, rsp_status_ff};

   // memories, registered read
   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[head_waddr] <= head_wdata;
      end
      head_q <= head_mem[bucket_ff];
   end

   always_ff @(posedge clock) begin
      if (chain_we) begin
         chain_mem[chain_waddr] <= chain_wdata;
      end
      chain_q <= chain_mem[chain_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= chbt_pkg::S_CLEAR;
         bc_ff        <= chbt_pkg::BCNT_RESET;
         clr_ff       <= '0;
         coll_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bc_ff        <= bc_in;
         clr_ff       <= clr_in;
         coll_ff      <= coll_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      bucket_ff     <= bucket_in;
      mag_ff        <= mag_in;
      rem_ff        <= rem_in;
      n_ff          <= n_in;
      dcnt_ff       <= dcnt_in;
      action_ff     <= action_in;
      info_ff       <= info_in;
      hinfo_ff      <= hinfo_in;
      len_ff        <= len_in;
      idx_ff        <= idx_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_info_ff   <= rsp_info_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_coll_ff   <= rsp_coll_in;
   end

   always_comb begin
      state_in      = state_ff;
      bc_in         = csr_wen ? csr_wdata : bc_ff;
      clr_in        = clr_ff;
      bucket_in     = bucket_ff;
      mag_in        = mag_ff;
      rem_in        = rem_ff;
      n_in          = n_ff;
      dcnt_in       = dcnt_ff;
      action_in     = action_ff;
      info_in       = info_ff;
      hinfo_in      = hinfo_ff;
      len_in        = len_ff;
      idx_in        = idx_ff;
      status_in     = status_ff;
      coll_in       = coll_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_info_in   = rsp_info_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_coll_in   = rsp_coll_ff;
      head_we       = 1'b0;
      head_waddr    = bucket_ff;
      head_wdata    = '0;
      chain_we      = 1'b0;
      chain_waddr   = {bucket_ff, idx_ff[SLOT_W-1:0]};
      chain_wdata   = chain_q;

      unique case (state_ff)
         chbt_pkg::S_CLEAR: begin
            // empty every head, one bucket a cycle
            head_we    = 1'b1;
            head_waddr = clr_ff;
            clr_in     = clr_ff + BW'(1);
            if (clr_ff == BW'(BUCKETS - 1)) begin
               state_in = chbt_pkg::S_IDLE;
            end
         end
         chbt_pkg::S_IDLE: begin
            if (req_tvalid) begin
               action_in = req_tdata[1:0];
               info_in   = req_tdata[64:34];
               n_in      = n_eff;
               mag_in    = req_mag;
               rem_in    = '0;
               dcnt_in   = '0;
               if (req_mag < 32'(n_eff)) begin
                  bucket_in = req_mag[BW-1:0];
                  state_in  = chbt_pkg::S_HRD;
               end else begin
                  state_in  = chbt_pkg::S_DIV;
               end
            end
         end
         chbt_pkg::S_DIV: begin
            rem_in  = rem_next;
            mag_in  = {mag_ff[30:0], 1'b0};
            dcnt_in = dcnt_ff + 5'd1;
            if (dcnt_ff == 5'd31) begin
               bucket_in = rem_next[BW-1:0];
               state_in  = chbt_pkg::S_HRD;
            end
         end
         chbt_pkg::S_HRD: begin
            state_in = chbt_pkg::S_HEAD;
         end
         chbt_pkg::S_HEAD: begin
            hinfo_in = hq_info;
            len_in   = hq_len;
            idx_in   = '0;
            unique case (action_ff)
               chbt_pkg::ACT_ADD: begin
                  status_in = chbt_pkg::ST_OK;
                  state_in  = chbt_pkg::S_EMIT;
                  if (!hq_valid) begin
                     head_we    = 1'b1;
                     head_wdata = {1'b1, info_ff, hq_len};
                  end else if (hq_len >= LEN_W'(CHAIN_DEPTH)) begin
                     status_in = chbt_pkg::ST_FULL;
                  end else begin
                     chain_we    = 1'b1;
                     chain_waddr = {bucket_ff, hq_len[SLOT_W-1:0]};
                     chain_wdata = info_ff;
                     head_we     = 1'b1;
                     head_wdata  = {1'b1, hq_info, hq_len + LEN_W'(1)};
                     coll_in     = coll_ff + CW'(1);
                  end
               end
               chbt_pkg::ACT_DEL, chbt_pkg::ACT_EXIST: begin
                  if (hq_valid && hq_info == info_ff) begin
                     status_in = chbt_pkg::ST_OK;
                     state_in  = chbt_pkg::S_EMIT;
                     if (action_ff == chbt_pkg::ACT_DEL) begin
                        if (hq_len == '0) begin
                           head_we    = 1'b1;
                           head_wdata = '0;
                        end else begin
                           state_in = chbt_pkg::S_PRD;
                        end
                     end
                  end else if (hq_len == '0) begin
                     status_in = chbt_pkg::ST_MISS;
                     state_in  = chbt_pkg::S_EMIT;
                  end else begin
                     state_in = chbt_pkg::S_SCRD;
                  end
               end
               chbt_pkg::ACT_LIST: begin
                  if (!hq_valid) begin
                     status_in = chbt_pkg::ST_MISS;
                     state_in  = chbt_pkg::S_EMIT;
                  end else begin
                     state_in = chbt_pkg::S_LHEAD;
                  end
               end
               default: begin
                  state_in = chbt_pkg::S_IDLE;
               end
            endcase
         end
         // promote the first chain entry into the head
         chbt_pkg::S_PRD: begin
            state_in = chbt_pkg::S_PDAT;
         end
         chbt_pkg::S_PDAT: begin
            hinfo_in = chain_q;
            idx_in   = LEN_W'(1);
            state_in = (len_ff > LEN_W'(1)) ? chbt_pkg::S_SRD : chbt_pkg::S_FIN;
         end
         // chain search for delete and exist
         chbt_pkg::S_SCRD: begin
            state_in = chbt_pkg::S_SCHK;
         end
         chbt_pkg::S_SCHK: begin
            if (chain_q == info_ff) begin
               if (action_ff == chbt_pkg::ACT_DEL) begin
                  idx_in   = idx_inc;
                  state_in = (idx_inc < len_ff) ? chbt_pkg::S_SRD : chbt_pkg::S_FIN;
               end else begin
                  status_in = chbt_pkg::ST_OK;
                  state_in  = chbt_pkg::S_EMIT;
               end
            end else if (idx_inc >= len_ff) begin
               status_in = chbt_pkg::ST_MISS;
               state_in  = chbt_pkg::S_EMIT;
            end else begin
               idx_in   = idx_inc;
               state_in = chbt_pkg::S_SCRD;
            end
         end
         // close the gap: entry idx moves down to idx - 1
         chbt_pkg::S_SRD: begin
            state_in = chbt_pkg::S_SWR;
         end
         chbt_pkg::S_SWR: begin
            chain_we    = 1'b1;
            chain_waddr = {bucket_ff, idx_ff[SLOT_W-1:0] - SLOT_W'(1)};
            chain_wdata = chain_q;
            idx_in      = idx_inc;
            state_in    = (idx_inc < len_ff) ? chbt_pkg::S_SRD : chbt_pkg::S_FIN;
         end
         chbt_pkg::S_FIN: begin
            head_we    = 1'b1;
            head_wdata = {1'b1, hinfo_ff, len_ff - LEN_W'(1)};
            if (coll_ff != '0) begin
               coll_in = coll_ff - CW'(1);
            end
            status_in = chbt_pkg::ST_OK;
            state_in  = chbt_pkg::S_EMIT;
         end
         // listing: head beat, then one beat per chain entry
         chbt_pkg::S_LHEAD: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = chbt_pkg::ST_OK;
               rsp_info_in   = hinfo_ff;
               rsp_last_in   = (len_ff == '0);
               rsp_coll_in   = coll_ext[chbt_pkg::COLL_W-1:0];
               state_in      = (len_ff == '0) ? chbt_pkg::S_IDLE : chbt_pkg::S_LRD;
            end
         end
         chbt_pkg::S_LRD: begin
            state_in = chbt_pkg::S_LDAT;
         end
         chbt_pkg::S_LDAT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = chbt_pkg::ST_OK;
               rsp_info_in   = chain_q;
               rsp_last_in   = (idx_inc == len_ff);
               rsp_coll_in   = coll_ext[chbt_pkg::COLL_W-1:0];
               idx_in        = idx_inc;
               state_in      = (idx_inc == len_ff) ? chbt_pkg::S_IDLE : chbt_pkg::S_LRD;
            end
         end
         chbt_pkg::S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_info_in   = '0;
               rsp_last_in   = 1'b1;
               rsp_coll_in   = coll_ext[chbt_pkg::COLL_W-1:0];
               state_in      = chbt_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = chbt_pkg::S_IDLE;
         end
      endcase
   end

endmodule
